// ===== rtl/core/fap_pkg.sv =====
package fap_pkg;

  // Number of zero-offset registers on the configuration port.
  localparam int NUM_REGS     = 6;
  localparam int DEF_CHANNELS = 6;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;

  // Field widths.
  localparam int ANGLE_W  = 12;
  localparam int TARGET_W = 8;
  localparam int CHAN_W   = 3;
  localparam int ERR_W    = 18;
  localparam int KP_W     = 14;
  localparam int KI_W     = 12;
  localparam int INTEG_W  = 13;
  localparam int PPROD_W  = 32;
  localparam int IPROD_W  = 25;
  localparam int TOTAL_W  = 24;
  localparam int DRIVE_W  = 13;
  localparam int CMP_W    = 10;

  // Filter and loop limits.
  localparam int ANGLE_MAX    = 4000;
  localparam int INT_WINDOW   = 600;
  localparam int INT_LIMIT    = 2500;
  localparam int UP_LIMIT     = 600;
  localparam int DOWN_LIMIT   = -480;
  localparam int UP_CLAMP     = 2500;
  localparam int DOWN_CLAMP   = -1500;
  localparam int MOVE_COMPARE = 350;

  // Stop-band compare is (455*11 - 2*drive) / 11; the divide by 11 is a
  // multiply by ceil(2^16/11), exact for numerators below 2^15.
  localparam int STOP_BASE  = 5005;
  localparam int RECIP_11   = 5958;
  localparam int RECIP_SH   = 16;

  // Q8.8 gain schedule.
  localparam int KP0_BASE = 896;
  localparam int KP_BASE  = 768;
  localparam int KI_BASE  = 128;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  // Result of the channel stage, handed to the PI arithmetic.
  typedef struct packed {
    logic                       is_ctrl;
    logic [ANGLE_W-1:0]         filt;
    logic signed [ERR_W-1:0]    err;
    logic [KP_W-1:0]            kp;
    logic signed [INTEG_W-1:0]  integ;
    logic [KI_W-1:0]            ki;
  } stage1_t;

endpackage

// ===== rtl/core/fap_chan_state.sv =====
module fap_chan_state #(
  parameter int CHANNELS = fap_pkg::DEF_CHANNELS
) (
  input  logic                                                   clk,
  input  logic                                                   rst,
  input  logic                                                   in_valid,
  output logic                                                   in_ready,
  input  logic                                                   operation,
  input  logic [fap_pkg::CHAN_W-1:0]                             channel,
  input  logic [fap_pkg::ANGLE_W-1:0]                            angle_sample,
  input  logic [fap_pkg::TARGET_W-1:0]                           target_angle,
  input  logic                                                   new_command,
  input  logic [fap_pkg::NUM_REGS-1:0][fap_pkg::ANGLE_W-1:0]     zero_offset,
  output logic                                                   s1_valid,
  output fap_pkg::stage1_t                                       s1,
  input  logic                                                   s1_ready
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [fap_pkg::ANGLE_W-1:0]        hist0 [CHANNELS];
  logic [fap_pkg::ANGLE_W-1:0]        hist1 [CHANNELS];
  logic [fap_pkg::ANGLE_W-1:0]        hist2 [CHANNELS];
  logic [fap_pkg::ANGLE_W-1:0]        filt_store [CHANNELS];
  logic signed [fap_pkg::INTEG_W-1:0] integ [CHANNELS];
  logic [fap_pkg::KP_W-1:0]           kp [CHANNELS];
  logic [fap_pkg::KI_W-1:0]           ki [CHANNELS];

  logic                               accept;
  logic                               in_range;
  logic [IDX_W-1:0]                   idx;
  logic [fap_pkg::ANGLE_W+1:0]        avg_sum;
  logic [fap_pkg::ANGLE_W-1:0]        avg;
  logic [fap_pkg::ANGLE_W-1:0]        avg_cl;
  logic [fap_pkg::ANGLE_W-1:0]        off;
  logic signed [fap_pkg::ANGLE_W:0]   diff;
  logic signed [fap_pkg::ANGLE_W:0]   wrapped;
  logic [fap_pkg::ANGLE_W-1:0]        filt_new;
  logic [fap_pkg::KP_W-1:0]           kp_new;
  logic [fap_pkg::KI_W-1:0]           t8;
  logic [fap_pkg::KI_W-1:0]           rnd_y;
  logic [fap_pkg::KI_W-1:0]           rnd_s;
  logic [fap_pkg::KI_W-1:0]           ki_new;
  logic [fap_pkg::KP_W-1:0]           kp_use;
  logic [fap_pkg::KI_W-1:0]           ki_use;
  logic signed [fap_pkg::ERR_W-1:0]   err;
  logic signed [fap_pkg::ERR_W-1:0]   inc;
  logic                               in_win;
  logic signed [fap_pkg::INTEG_W:0]   sum_raw;
  logic signed [fap_pkg::INTEG_W-1:0] sum_cl;

  assign in_ready = !s1_valid || s1_ready;
  assign accept   = in_valid && in_ready;
  assign in_range = (int'(channel) < CHANNELS);
  assign idx      = IDX_W'(channel);

  // Four-tap moving average, clamped, then offset-corrected with wrap.
  always_comb begin
    avg_sum = (fap_pkg::ANGLE_W+2)'(angle_sample) + (fap_pkg::ANGLE_W+2)'(hist0[idx])
            + (fap_pkg::ANGLE_W+2)'(hist1[idx]) + (fap_pkg::ANGLE_W+2)'(hist2[idx]);
    avg     = avg_sum[fap_pkg::ANGLE_W+1:2];
    avg_cl  = (int'(avg) > fap_pkg::ANGLE_MAX) ? fap_pkg::ANGLE_W'(fap_pkg::ANGLE_MAX) : avg;
    off     = (int'(channel) < fap_pkg::NUM_REGS) ? zero_offset[channel]
                                                   : '0;
    diff    = $signed({1'b0, avg_cl}) - $signed({1'b0, off});
    wrapped = diff + (fap_pkg::ANGLE_W+1)'(fap_pkg::ANGLE_MAX);
    if (diff >= 0) begin
      filt_new = diff[fap_pkg::ANGLE_W-1:0];
    end else if (wrapped >= 0) begin
      filt_new = wrapped[fap_pkg::ANGLE_W-1:0];
    end else begin
      filt_new = '0;
    end
  end

  // Gain schedule. Ki = 128 + 8t + round(8t/255); the divide by 255 uses
  // (y + (y >> 8) + 1) >> 8, which is exact for these small y.
  always_comb begin
    if (channel == '0) begin
      kp_new = fap_pkg::KP_W'(fap_pkg::KP0_BASE) + fap_pkg::KP_W'({target_angle, 4'b0})
             + fap_pkg::KP_W'({target_angle, 3'b0});
    end else begin
      kp_new = fap_pkg::KP_W'(fap_pkg::KP_BASE) + fap_pkg::KP_W'({target_angle, 5'b0});
    end
    t8     = fap_pkg::KI_W'({target_angle, 3'b0});
    rnd_y  = t8 + fap_pkg::KI_W'(127);
    rnd_s  = rnd_y + (rnd_y >> 8) + fap_pkg::KI_W'(1);
    ki_new = fap_pkg::KI_W'(fap_pkg::KI_BASE) + t8 + (rnd_s >> 8);
    kp_use = new_command ? kp_new : kp[idx];
    ki_use = new_command ? ki_new : ki[idx];
  end

  // Error and integral update; the arithmetic shift is a floor divide by 64.
  always_comb begin
    err    = $signed({2'b0, target_angle, 8'b0})
           - $signed({(fap_pkg::ERR_W-fap_pkg::ANGLE_W)'(0), filt_store[idx]});
    in_win = (err > -fap_pkg::INT_WINDOW) && (err < fap_pkg::INT_WINDOW);
    inc    = err >>> 6;
    if (in_win) begin
      sum_raw = (fap_pkg::INTEG_W+1)'(integ[idx]) + inc[fap_pkg::INTEG_W:0];
    end else begin
      sum_raw = (fap_pkg::INTEG_W+1)'(integ[idx]);
    end
    if (sum_raw > fap_pkg::INT_LIMIT) begin
      sum_cl = fap_pkg::INTEG_W'(fap_pkg::INT_LIMIT);
    end else if (sum_raw < -fap_pkg::INT_LIMIT) begin
      sum_cl = fap_pkg::INTEG_W'(-fap_pkg::INT_LIMIT);
    end else begin
      sum_cl = sum_raw[fap_pkg::INTEG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        hist0[i]      <= '0;
        hist1[i]      <= '0;
        hist2[i]      <= '0;
        filt_store[i] <= '0;
        integ[i]      <= '0;
        kp[i]         <= '0;
        ki[i]         <= '0;
      end
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_ready) begin
        s1_valid <= 1'b0;
      end
      if (accept && in_range) begin
        if (!operation) begin
          hist2[idx]      <= hist1[idx];
          hist1[idx]      <= hist0[idx];
          hist0[idx]      <= angle_sample;
          filt_store[idx] <= filt_new;
        end else begin
          integ[idx] <= sum_cl;
          if (new_command) begin
            kp[idx] <= kp_new;
            ki[idx] <= ki_new;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1.is_ctrl <= in_range && operation;
      if (!in_range) begin
        s1.filt <= '0;
      end else if (operation) begin
        s1.filt <= filt_store[idx];
      end else begin
        s1.filt <= filt_new;
      end
      s1.err   <= err;
      s1.kp    <= kp_use;
      s1.integ <= sum_cl;
      s1.ki    <= ki_use;
    end
  end

endmodule

// ===== rtl/core/fap_pi_math.sv =====
module fap_pi_math (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s1_valid,
  input  fap_pkg::stage1_t                    s1,
  output logic                                s1_ready,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fap_pkg::ANGLE_W-1:0]         filtered_angle,
  output logic [1:0]                          direction,
  output logic signed [fap_pkg::DRIVE_W-1:0]  drive_level,
  output logic [fap_pkg::CMP_W-1:0]           pwm_compare
);

  localparam int NUM_W  = fap_pkg::DRIVE_W;
  localparam int CPROD_W = 2 * NUM_W;

  // Product stage.
  logic                               s2_valid;
  logic                               s2_ready;
  logic                               s2_ctrl;
  logic [fap_pkg::ANGLE_W-1:0]        s2_filt;
  logic signed [fap_pkg::PPROD_W-1:0] s2_pprod;
  logic signed [fap_pkg::IPROD_W-1:0] s2_iprod;
  logic signed [fap_pkg::ERR_W+fap_pkg::KP_W:0]      pprod_full;
  logic signed [fap_pkg::INTEG_W+fap_pkg::KI_W:0]    iprod_full;

  // Sum stage.
  logic                               s3_valid;
  logic                               s3_ready;
  logic                               s3_ctrl;
  logic [fap_pkg::ANGLE_W-1:0]        s3_filt;
  logic signed [fap_pkg::TOTAL_W-1:0] s3_total;
  logic signed [fap_pkg::PPROD_W-1:0] p_adj;
  logic signed [fap_pkg::PPROD_W-1:0] t_raw;
  logic signed [fap_pkg::PPROD_W-1:0] t_adj;
  logic signed [fap_pkg::TOTAL_W-1:0] total;

  // Decision stage.
  logic                               out_slot_ready;
  fap_pkg::dir_t                      dir_n;
  logic signed [fap_pkg::DRIVE_W-1:0] drive_n;
  logic [NUM_W-1:0]                   num;
  logic [CPROD_W-1:0]                 cprod;
  logic [fap_pkg::CMP_W-1:0]          cmp_n;

  assign out_slot_ready = !out_valid || out_ready;
  assign s3_ready       = !s3_valid || out_slot_ready;
  assign s2_ready       = !s2_valid || s3_ready;
  assign s1_ready       = s2_ready;

  assign pprod_full = s1.err * $signed({1'b0, s1.kp});
  assign iprod_full = s1.integ * $signed({1'b0, s1.ki});

  // Both divides by 256 truncate toward zero: bias negatives by 255.
  always_comb begin
    p_adj = s2_pprod + (s2_pprod[fap_pkg::PPROD_W-1] ? fap_pkg::PPROD_W'(255) : '0);
    t_raw = {p_adj[fap_pkg::PPROD_W-1:8], 8'b0}
          + {{(fap_pkg::PPROD_W-fap_pkg::IPROD_W){s2_iprod[fap_pkg::IPROD_W-1]}}, s2_iprod};
    t_adj = t_raw + (t_raw[fap_pkg::PPROD_W-1] ? fap_pkg::PPROD_W'(255) : '0);
    total = t_adj[fap_pkg::PPROD_W-1:8];
  end

  always_comb begin
    if (s3_total > fap_pkg::UP_LIMIT) begin
      dir_n   = fap_pkg::DIR_UP;
      drive_n = (s3_total > fap_pkg::UP_CLAMP) ? fap_pkg::DRIVE_W'(fap_pkg::UP_CLAMP)
                                                : s3_total[fap_pkg::DRIVE_W-1:0];
    end else if (s3_total < fap_pkg::DOWN_LIMIT) begin
      dir_n   = fap_pkg::DIR_DOWN;
      drive_n = (s3_total < fap_pkg::DOWN_CLAMP) ? fap_pkg::DRIVE_W'(fap_pkg::DOWN_CLAMP)
                                                  : s3_total[fap_pkg::DRIVE_W-1:0];
    end else begin
      dir_n   = fap_pkg::DIR_STOP;
      drive_n = s3_total[fap_pkg::DRIVE_W-1:0];
    end
    // The numerator stays within 3805..5965 in the stop band, so modular
    // arithmetic at this width gives the exact value.
    num   = NUM_W'(fap_pkg::STOP_BASE) - {drive_n[NUM_W-2:0], 1'b0};
    cprod = num * NUM_W'(fap_pkg::RECIP_11);
    case (dir_n)
      fap_pkg::DIR_STOP: cmp_n = cprod[fap_pkg::RECIP_SH +: fap_pkg::CMP_W];
      default:           cmp_n = fap_pkg::CMP_W'(fap_pkg::MOVE_COMPARE);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_valid && s2_ready) begin
        s2_valid <= 1'b1;
      end else if (s3_ready) begin
        s2_valid <= 1'b0;
      end
      if (s2_valid && s3_ready) begin
        s3_valid <= 1'b1;
      end else if (out_slot_ready) begin
        s3_valid <= 1'b0;
      end
      if (s3_valid && out_slot_ready) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s2_ready) begin
      s2_ctrl  <= s1.is_ctrl;
      s2_filt  <= s1.filt;
      s2_pprod <= pprod_full[fap_pkg::PPROD_W-1:0];
      s2_iprod <= iprod_full[fap_pkg::IPROD_W-1:0];
    end
    if (s2_valid && s3_ready) begin
      s3_ctrl  <= s2_ctrl;
      s3_filt  <= s2_filt;
      s3_total <= total;
    end
    if (s3_valid && out_slot_ready) begin
      filtered_angle <= s3_filt;
      if (s3_ctrl) begin
        direction   <= dir_n;
        drive_level <= drive_n;
        pwm_compare <= cmp_n;
      end else begin
        direction   <= fap_pkg::DIR_STOP;
        drive_level <= '0;
        pwm_compare <= '0;
      end
    end
  end

endmodule

// ===== rtl/core/finger_angle_pi_servo.sv =====
// Multi-channel finger angle servo. A sample transfer (operation 0) pushes a
// 12-bit angle reading into its channel's four-tap moving average; the
// average is clamped to 4000, the channel's zero offset is subtracted, and a
// negative result wraps by adding 4000 (saturating at zero). A control
// transfer (operation 1) optionally reschedules the channel's Q8.8 gains from
// the target byte, forms the error against the filtered angle, updates the
// windowed and clamped integral, and returns direction, drive level and PWM
// compare value. Every input transfer yields exactly one result transfer;
// channels at or above CHANNELS return an all-zero result and change nothing.
// The block takes one transfer per clock cycle unless every stage is full and
// the result at the output is held: all channel state is read and written in
// the acceptance cycle, and the gain products, the sum and the branch decision
// follow in a four-register pipeline. Each stage stalls only when the one after
// it is full and cannot drain, so input transfers keep flowing while a finished
// result waits at the output, until every stage is full. The zero offsets are written through the APB port at
// byte addresses 0, 4, ... 20 and should only change while the block is idle.
module finger_angle_pi_servo #(
  parameter int CHANNELS = fap_pkg::DEF_CHANNELS
) (
  input  logic                                clk,
  input  logic                                rst,

  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fap_pkg::ADDR_W-1:0]          paddr,
  input  logic [fap_pkg::DATA_W-1:0]          pwdata,
  output logic [fap_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,

  // Input channel.
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                operation,
  input  logic [fap_pkg::CHAN_W-1:0]          channel,
  input  logic [fap_pkg::ANGLE_W-1:0]         angle_sample,
  input  logic [fap_pkg::TARGET_W-1:0]        target_angle,
  input  logic                                new_command,

  // Result channel.
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [fap_pkg::ANGLE_W-1:0]         filtered_angle,
  output logic [1:0]                          direction,
  output logic signed [fap_pkg::DRIVE_W-1:0]  drive_level,
  output logic [fap_pkg::CMP_W-1:0]           pwm_compare
);

  // Word index of the register that a transfer on the APB port addresses.
  logic [fap_pkg::ADDR_W-3:0]                             reg_idx;
  logic                                                   cfg_write;
  logic [fap_pkg::NUM_REGS-1:0][fap_pkg::ANGLE_W-1:0]     zero_offset;

  logic                                                   s1_valid;
  logic                                                   s1_ready;
  fap_pkg::stage1_t                                       s1;

  // The port never inserts wait states.
  assign pready    = 1'b1;
  assign reg_idx   = paddr[fap_pkg::ADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Reads of addresses past the last offset register return zero.
  always_comb begin
    if (int'(reg_idx) < fap_pkg::NUM_REGS) begin
      prdata = fap_pkg::DATA_W'(zero_offset[reg_idx]);
    end else begin
      prdata = '0;
    end
  end

  // Offset registers keep only the low 12 bits of the written word; writes
  // past the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_offset <= '0;
    end else if (cfg_write && (int'(reg_idx) < fap_pkg::NUM_REGS)) begin
      zero_offset[reg_idx] <= pwdata[fap_pkg::ANGLE_W-1:0];
    end
  end

  // Channel stage: filter history, filtered angle, integral and gains live
  // here and are updated in the cycle the input transfer is taken.
  fap_chan_state #(
    .CHANNELS (CHANNELS)
  ) u_chan_state (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .channel      (channel),
    .angle_sample (angle_sample),
    .target_angle (target_angle),
    .new_command  (new_command),
    .zero_offset  (zero_offset),
    .s1_valid     (s1_valid),
    .s1           (s1),
    .s1_ready     (s1_ready)
  );

  // PI arithmetic: products, truncating sums, branch clamp and the compare.
  fap_pi_math u_pi_math (
    .clk            (clk),
    .rst            (rst),
    .s1_valid       (s1_valid),
    .s1             (s1),
    .s1_ready       (s1_ready),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .filtered_angle (filtered_angle),
    .direction      (direction),
    .drive_level    (drive_level),
    .pwm_compare    (pwm_compare)
  );

  // The pipeline only refuses input when every stage is full and the result
  // at the output is not being taken.
  a_stall_only_when_full: assert property (
    @(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready)
  ) else $error("input stalled while the output could drain");

  // A moving motor always gets the fixed compare value.
  a_moving_compare: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && (direction != fap_pkg::DIR_STOP))
      |-> (pwm_compare == fap_pkg::CMP_W'(fap_pkg::MOVE_COMPARE))
  ) else $error("moving result without the fixed compare value");

  // A stopped motor carries a drive inside the dead band.
  a_stop_band: assert property (
    @(posedge clk) disable iff (rst)
    (out_valid && (direction == fap_pkg::DIR_STOP))
      |-> ((drive_level >= fap_pkg::DOWN_LIMIT) && (drive_level <= fap_pkg::UP_LIMIT))
  ) else $error("stop result with drive outside the dead band");

  // The filtered angle never exceeds the clamp.
  a_filt_range: assert property (
    @(posedge clk) disable iff (rst)
    out_valid |-> (int'(filtered_angle) <= fap_pkg::ANGLE_MAX)
  ) else $error("filtered angle above its clamp");

endmodule
